### sv/sopfsm_pkg.sv
// Shared types and constants for the sum-of-products state machine engine.
// Used by sopfsm_ctrl, sopfsm_datapath and the top level.
package sopfsm_pkg;

  localparam int MAX_STATE_BITS = 8;
  localparam int MAX_INPUT_BITS = 8;
  localparam int MAX_OUTPUTS    = 8;
  localparam int MAX_TERMS      = 16;
  localparam int FEED_BITS      = 16;
  localparam int EQ_COUNT       = 16;

  localparam int EQ_W    = $clog2(EQ_COUNT);
  localparam int TERM_W  = $clog2(MAX_TERMS);
  localparam int CNT_W   = TERM_W + 1;
  localparam int BIT_W   = 3;
  localparam int CFG_W   = 4;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_COUNT = 2'd1,
    REQ_STEP  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_STATE_BITS = 2'd0,
    CFG_INPUT_BITS = 2'd1,
    CFG_OUTPUTS    = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  // phase of an equation read: next-state bits first, outputs second
  typedef enum logic {
    PH_STATE = 1'b0,
    PH_OUT   = 1'b1
  } phase_t;

  typedef struct packed {
    logic             start;      // latch feed, clear accumulators
    logic             load_term;  // write one product term
    logic             set_count;  // write one equation's term count
    logic             issue;      // read one equation row
    phase_t           phase;
    logic [BIT_W-1:0] bit_idx;
    logic             finish;     // commit state, load result register
  } cmd_t;

  typedef struct packed {
    logic [BIT_W-1:0] ns_last;
    logic [BIT_W-1:0] no_last;
  } stat_t;

endpackage

### sv/sopfsm_ctrl.sv
// Sequencer for the sum-of-products engine: accepts requests, walks the
// equations of a step one per cycle and owns the result valid flag. Uses sopfsm_pkg.
module sopfsm_ctrl import sopfsm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  input  logic  [1:0] in_req,
  output logic  in_tready,
  output logic  out_tvalid,
  input  logic  out_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_STATE = 5'b00010,
    S_OUT   = 5'b00100,
    S_LAST  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [BIT_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  req_t             req;

  assign req        = req_t'(in_req);
  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.bit_idx   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (req)
            REQ_LOAD:  cmd.load_term = 1'b1;
            REQ_COUNT: cmd.set_count = 1'b1;
            REQ_STEP: begin
              cmd.start = 1'b1;
              idx_nxt   = '0;
              state_nxt = S_STATE;
            end
            default: ;
          endcase
        end
      end
      S_STATE: begin
        cmd.issue = 1'b1;
        cmd.phase = PH_STATE;
        if (idx_r == stat.ns_last) begin
          idx_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_OUT: begin
        cmd.issue = 1'b1;
        cmd.phase = PH_OUT;
        if (idx_r == stat.no_last) begin
          state_nxt = S_LAST;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_LAST: state_nxt = S_DONE;
      S_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_tready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> state_r == S_STATE) else $error("step did not start");
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (state_r == S_IDLE && out_valid_r)) else $error("finish lost");
  a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue && cmd.phase == PH_STATE) |-> cmd.bit_idx <= stat.ns_last)
    else $error("state equation index out of range");
`endif

endmodule

### sv/sopfsm_datapath.sv
// Datapath of the sum-of-products engine: configuration registers, term memory
// (one equation per row), term counts, product-term evaluator and result register.
// Uses sopfsm_pkg; driven by cmd_t from sopfsm_ctrl.
module sopfsm_datapath import sopfsm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [1:0]                cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  cmd_t                      cmd,
  output stat_t                     stat,
  input  logic [EQ_W-1:0]           equation_index,
  input  logic [TERM_W-1:0]         term_index,
  input  logic [CNT_W-1:0]          term_count,
  input  logic [FEED_BITS-1:0]      true_mask,
  input  logic [FEED_BITS-1:0]      false_mask,
  input  logic [MAX_INPUT_BITS-1:0] input_bits,
  output logic [MAX_STATE_BITS-1:0] next_state,
  output logic [MAX_OUTPUTS-1:0]    output_bits
);

  logic [CFG_W-1:0] ns_cfg_r, ni_cfg_r, no_cfg_r;

  logic [2*FEED_BITS-1:0] term_mem [EQ_COUNT][MAX_TERMS];
  logic [2*FEED_BITS-1:0] row_r [MAX_TERMS];
  logic [CNT_W-1:0]       count_r [EQ_COUNT];
  logic [CNT_W-1:0]       cnt_r;
  logic                   rd_valid_r;
  phase_t                 rd_phase_r;
  logic [BIT_W-1:0]       rd_bit_r;

  logic [FEED_BITS-1:0]      feed_r, letters_r, smask_r;
  logic [MAX_STATE_BITS-1:0] cur_state_r, ns_acc_r, out_ns_r;
  logic [MAX_OUTPUTS-1:0]    out_acc_r, out_bits_r;
  logic [BIT_W-1:0]          ns_last_r, no_last_r;

  logic [CFG_W-1:0]     ns_c, ni_c, no_c;
  logic [CFG_W:0]       nl;
  logic [FEED_BITS-1:0] smask_c, letters_c, imask_c, feed_c, feed_eval;
  logic [FEED_BITS-1:0] present [MAX_TERMS];
  logic [EQ_W-1:0]      rd_addr;
  logic                 hit;

  // saturate the registers into their ranges
  always_comb begin
    ns_c = (ns_cfg_r == '0) ? CFG_W'(1) :
           (ns_cfg_r > CFG_W'(MAX_STATE_BITS)) ? CFG_W'(MAX_STATE_BITS) : ns_cfg_r;
    ni_c = (ni_cfg_r > CFG_W'(MAX_INPUT_BITS)) ? CFG_W'(MAX_INPUT_BITS) : ni_cfg_r;
    no_c = (no_cfg_r == '0) ? CFG_W'(1) :
           (no_cfg_r > CFG_W'(MAX_OUTPUTS)) ? CFG_W'(MAX_OUTPUTS) : no_cfg_r;
    nl   = (CFG_W+1)'(ns_c) + (CFG_W+1)'(ni_c);
    if (nl > (CFG_W+1)'(FEED_BITS)) nl = (CFG_W+1)'(FEED_BITS);
    letters_c = FEED_BITS'(({(FEED_BITS+1){1'b0}} | (FEED_BITS+1)'(1)) << nl) - 1'b1;
    smask_c   = FEED_BITS'((FEED_BITS'(1) << ns_c) - 1'b1);
    imask_c   = FEED_BITS'((FEED_BITS'(1) << ni_c) - 1'b1);
    feed_c    = ((FEED_BITS'(cur_state_r) & smask_c) |
                 ((FEED_BITS'(input_bits) & imask_c) << ns_c)) & letters_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ns_cfg_r <= CFG_W'(1);
      ni_cfg_r <= '0;
      no_cfg_r <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STATE_BITS: ns_cfg_r <= cfg_data;
        CFG_INPUT_BITS: ni_cfg_r <= cfg_data;
        CFG_OUTPUTS:    no_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // term memory: one term written, one whole equation row read
  assign rd_addr = (cmd.phase == PH_OUT) ? EQ_W'(EQ_COUNT/2) + EQ_W'(cmd.bit_idx)
                                         : EQ_W'(cmd.bit_idx);

  always_ff @(posedge clk) begin
    if (cmd.load_term) term_mem[equation_index][term_index] <= {false_mask, true_mask};
    if (cmd.issue) begin
      row_r <= term_mem[rd_addr];
      cnt_r <= count_r[rd_addr];
    end
    rd_phase_r <= cmd.phase;
    rd_bit_r   <= cmd.bit_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < EQ_COUNT; e++) count_r[e] <= '0;
      rd_valid_r  <= 1'b0;
      cur_state_r <= '0;
    end else begin
      rd_valid_r <= cmd.issue;
      if (cmd.set_count)
        count_r[equation_index] <= (term_count > CNT_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS)
                                                                   : term_count;
      if (cmd.finish) cur_state_r <= ns_acc_r;
    end
  end

  // one equation: OR over its terms of the AND of present literals
  always_comb begin
    feed_eval = (rd_phase_r == PH_OUT) ? ((feed_r & ~smask_r) | FEED_BITS'(ns_acc_r))
                                       : feed_r;
    hit = 1'b0;
    for (int t = 0; t < MAX_TERMS; t++) begin
      present[t] = (row_r[t][FEED_BITS-1:0] ^ row_r[t][2*FEED_BITS-1:FEED_BITS]) & letters_r;
      if ((CNT_W'(t) < cnt_r) &&
          (((feed_eval ^ row_r[t][FEED_BITS-1:0]) & present[t]) == '0))
        hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      feed_r    <= feed_c;
      letters_r <= letters_c;
      smask_r   <= smask_c;
      ns_last_r <= BIT_W'(ns_c - 1'b1);
      no_last_r <= BIT_W'(no_c - 1'b1);
      ns_acc_r  <= '0;
      out_acc_r <= '0;
    end else if (rd_valid_r) begin
      if (rd_phase_r == PH_STATE) ns_acc_r[rd_bit_r] <= hit;
      else                        out_acc_r[rd_bit_r] <= hit;
    end
    if (cmd.finish) begin
      out_ns_r   <= ns_acc_r;
      out_bits_r <= out_acc_r;
    end
  end

  assign stat.ns_last = ns_last_r;
  assign stat.no_last = no_last_r;
  assign next_state   = out_ns_r;
  assign output_bits  = out_bits_r;

`ifndef SYNTH
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !rd_valid_r) else $error("result taken before last equation");
  a_state_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_valid_r && rd_phase_r == PH_STATE) |-> rd_bit_r <= ns_last_r)
    else $error("state bit beyond range");
  a_out_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_valid_r && rd_phase_r == PH_OUT) |-> rd_bit_r <= no_last_r)
    else $error("output bit beyond range");
`endif

endmodule

### sv/sum_of_products_fsm_engine.sv
// Top level of the programmable sum-of-products state machine engine.
// Instantiates sopfsm_ctrl and sopfsm_datapath; uses sopfsm_pkg.
//
//   channel | dir | handshake              | payload
//   in_     | in  | in_tvalid / in_tready  | in_tdata, in_tuser (request kind)
//   out_    | out | out_tvalid / out_tready| out_tdata
//   cfg_    | in  | cfg_wr_en              | cfg_index, cfg_data
//
// A step reads the equations of the state bits in use, then those of the outputs
// in use; one equation row is read from the term memory and evaluated per cycle.
// Reset (rst_n, synchronous) clears the current state, term counts, configuration
// registers and sequencer; term memory and the result register are not cleared.
// A finished result sits in the output register while new requests are accepted;
// a step waits only if that register is still full when its own result is ready.
module sum_of_products_fsm_engine import sopfsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [3:0] equation_index, [7:4] term_index, [12:8] term_count, [28:13] true_mask,
  // [44:29] false_mask, [52:45] input_bits, [55:53] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] req_type
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] next_state, [15:8] output_bits
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  cmd_t                      cmd;
  stat_t                     stat;
  logic [MAX_STATE_BITS-1:0] next_state;
  logic [MAX_OUTPUTS-1:0]    output_bits;

  sopfsm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_req     (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  sopfsm_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .stat           (stat),
    .equation_index (in_tdata[3:0]),
    .term_index     (in_tdata[7:4]),
    .term_count     (in_tdata[12:8]),
    .true_mask      (in_tdata[28:13]),
    .false_mask     (in_tdata[44:29]),
    .input_bits     (in_tdata[52:45]),
    .next_state     (next_state),
    .output_bits    (output_bits)
  );

  assign out_tdata = {output_bits, next_state};

endmodule
